### rtl/srb_pkg.sv
// ----------------------------------------------------------------------------
// srb_pkg
// shared types, constants and helpers for the stream reassembly buffer
// ----------------------------------------------------------------------------
package srb_pkg;

   localparam int BUF_BYTES  = 4096;
   localparam int LANE_BYTES = 8;
   localparam int OFS_W      = 62;
   localparam int DATA_W     = 64;
   localparam int CNT_W      = 4;
   localparam int STAT_W     = 3;
   localparam int SLOT_W     = $clog2(BUF_BYTES);
   localparam int LANE_W     = $clog2(LANE_BYTES);
   localparam int ROWS       = BUF_BYTES / LANE_BYTES;
   localparam int ROW_W      = $clog2(ROWS);

   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_READ   = 1'b1;

   localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
   localparam logic [STAT_W-1:0] ST_OLD   = 3'd1;
   localparam logic [STAT_W-1:0] ST_FLOW  = 3'd2;
   localparam logic [STAT_W-1:0] ST_FINAL = 3'd3;
   localparam logic [STAT_W-1:0] ST_WAIT  = 3'd4;
   localparam logic [STAT_W-1:0] ST_END   = 3'd5;

   typedef struct packed {
      logic              cmd;
      logic [OFS_W-1:0]  stream_offset;
      logic [DATA_W-1:0] chunk_data;
      logic [CNT_W-1:0]  byte_count;
      logic              fin_flag;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [DATA_W-1:0] read_data;
      logic [CNT_W-1:0]  read_count;
      logic [OFS_W-1:0]  contiguous_point;
   } rsp_type;

   typedef struct packed {
      logic              cmd;
      logic [OFS_W-1:0]  offset;
      logic [DATA_W-1:0] data;
      logic [CNT_W-1:0]  count;
      logic              fin;
      logic [OFS_W:0]    end_pos;
   } work_type;

   // row of a bank that holds the byte of a run starting at slot pos
   function automatic logic [ROW_W-1:0] bank_row(input logic [SLOT_W-1:0] pos,
                                                 input logic [LANE_W-1:0] bank);
      bank_row = pos[SLOT_W-1:LANE_W] + ROW_W'(bank < pos[LANE_W-1:0]);
   endfunction

endpackage

### rtl/stream_reassembly_buffer.sv
// ----------------------------------------------------------------------------
// stream_reassembly_buffer
// rebuilds an in-order byte stream from out-of-order chunks
// ----------------------------------------------------------------------------
// scan: an accepted append is followed by mark scan passes, which repeat while
//   each pass moves the contiguous point by a full 8 bytes
// execution: the execution sequencer takes one request at a time and takes up
//   the next only after the result of the last is registered
// reset: synchronous; a clearing pass over every row of the valid marks follows,
//   during which requests are queued but not executed
module stream_reassembly_buffer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  srb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output srb_pkg::rsp_type rsp_data
);
   import srb_pkg::*;

   logic     f_valid, f_ready, b_valid, b_ready;
   work_type f_data, b_data;

   srb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (f_valid),
      .q_ready   (f_ready),
      .q_data    (f_data)
   );

   srb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_data),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_data  (b_data)
   );

   srb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (b_valid),
      .q_ready   (b_ready),
      .q_data    (b_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/srb_front.sv
// ----------------------------------------------------------------------------
// srb_front
// request intake: clamps the count and forms the end offset of a request
// ----------------------------------------------------------------------------
module srb_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  srb_pkg::req_type  req_data,
   output logic              q_valid,
   input  logic              q_ready,
   output srb_pkg::work_type q_data
);
   import srb_pkg::*;

   logic     valid_ff, valid_in;
   work_type data_ff, data_in;
   logic [CNT_W-1:0] count_c;

   assign req_ready = !valid_ff || q_ready;
   assign q_valid   = valid_ff;
   assign q_data    = data_ff;

   always_comb begin
      count_c = (req_data.byte_count > CNT_W'(LANE_BYTES)) ? CNT_W'(LANE_BYTES)
                                                          : req_data.byte_count;
      data_in         = data_ff;
      valid_in        = valid_ff && !q_ready;
      if (req_valid && req_ready) begin
         valid_in        = 1'b1;
         data_in.cmd     = req_data.cmd;
         data_in.offset  = req_data.stream_offset;
         data_in.data    = req_data.chunk_data;
         data_in.count   = count_c;
         data_in.fin     = req_data.fin_flag;
         data_in.end_pos = {1'b0, req_data.stream_offset} + (OFS_W+1)'(count_c);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

endmodule

### rtl/srb_queue.sv
// ----------------------------------------------------------------------------
// srb_queue
// two-entry request queue between intake and execution
// ----------------------------------------------------------------------------
module srb_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  srb_pkg::work_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output srb_pkg::work_type out_data
);
   import srb_pkg::*;

   work_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

### rtl/srb_back.sv
// ----------------------------------------------------------------------------
// srb_back
// execution: banked byte store and valid marks, offset state, result register
// ----------------------------------------------------------------------------
module srb_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_ready,
   input  srb_pkg::work_type q_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output srb_pkg::rsp_type  rsp_data
);
   import srb_pkg::*;

   localparam logic [2:0] S_CLEAR   = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_CLASS   = 3'd2;
   localparam logic [2:0] S_ACT     = 3'd3;
   localparam logic [2:0] S_SCAN_RD = 3'd4;
   localparam logic [2:0] S_SCAN_EV = 3'd5;
   localparam logic [2:0] S_RD_DATA = 3'd6;
   localparam logic [2:0] S_RESP    = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [ROW_W-1:0]  clr_row_ff, clr_row_in;
   work_type          cur_ff, cur_in;
   logic [OFS_W-1:0]  contig_ff, contig_in;
   logic [OFS_W-1:0]  consumed_ff, consumed_in;
   logic [OFS_W:0]    lim_ff, lim_in;
   logic              final_known_ff, final_known_in;
   logic [OFS_W-1:0]  final_size_ff, final_size_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [CNT_W-1:0]  skip_ff, skip_in;
   logic [CNT_W-1:0]  navail_ff, navail_in;
   logic [CNT_W-1:0]  room_ff, room_in;
   logic [DATA_W-1:0] rdata_ff, rdata_in;
   logic [CNT_W-1:0]  rcount_ff, rcount_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic [LANE_BYTES-1:0] mark_we, mark_wd, mark_rd_ff;
   logic [ROW_W-1:0]      mark_wa [LANE_BYTES];
   logic [ROW_W-1:0]      mark_ra [LANE_BYTES];
   logic [LANE_BYTES-1:0] byte_we;
   logic [ROW_W-1:0]      byte_wa [LANE_BYTES];
   logic [ROW_W-1:0]      byte_ra [LANE_BYTES];
   logic [7:0]            byte_wd [LANE_BYTES];
   logic [7:0]            byte_rd_ff [LANE_BYTES];

   logic              a_old, a_flow, a_final, off_lt, r_end, r_wait;
   logic [STAT_W-1:0] a_status, r_status;
   logic [OFS_W-1:0]  skip_diff, avail;
   logic [OFS_W:0]    r_want, room_diff;
   logic [CNT_W-1:0]  skip_c, navail_c, room_c, ones, ones_clip;
   logic [DATA_W-1:0] rdata_c;
   logic              run;
   logic [LANE_W-1:0] idx;

   assign q_ready   = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // classification
   always_comb begin
      a_old     = cur_ff.end_pos <= {1'b0, contig_ff};
      a_flow    = cur_ff.end_pos[OFS_W] || (cur_ff.end_pos > lim_ff);
      a_final   = final_known_ff && ((cur_ff.end_pos > {1'b0, final_size_ff}) ||
                  (cur_ff.fin && (cur_ff.end_pos != {1'b0, final_size_ff})));
      a_status  = a_old ? ST_OLD : a_flow ? ST_FLOW : a_final ? ST_FINAL : ST_OK;
      off_lt    = cur_ff.offset < contig_ff;
      skip_diff = contig_ff - cur_ff.offset;
      skip_c    = off_lt ? skip_diff[CNT_W-1:0] : '0;
      r_want    = {1'b0, consumed_ff} + (OFS_W+1)'(cur_ff.count);
      r_end     = final_known_ff && ((r_want > {1'b0, final_size_ff}) ||
                  (consumed_ff == final_size_ff));
      avail     = contig_ff - consumed_ff;
      r_wait    = avail < OFS_W'(cur_ff.count);
      navail_c  = (avail > OFS_W'(LANE_BYTES)) ? CNT_W'(LANE_BYTES) : avail[CNT_W-1:0];
      r_status  = r_end ? ST_END : r_wait ? ST_WAIT : ST_OK;
      room_diff = lim_ff - {1'b0, contig_ff};
      room_c    = (room_diff > (OFS_W+1)'(LANE_BYTES)) ? CNT_W'(LANE_BYTES)
                                                       : room_diff[CNT_W-1:0];
   end

   // scan of marks and read assembly
   always_comb begin
      run     = 1'b1;
      ones    = '0;
      rdata_c = '0;
      for (int i = 0; i < LANE_BYTES; i++) begin
         idx = contig_ff[LANE_W-1:0] + LANE_W'(i);
         run = run && mark_rd_ff[idx];
         if (run) begin
            ones = ones + 1'b1;
         end
      end
      for (int i = 0; i < LANE_BYTES; i++) begin
         idx = consumed_ff[LANE_W-1:0] + LANE_W'(i);
         if (CNT_W'(i) < navail_ff) begin
            rdata_c[8*i +: 8] = byte_rd_ff[idx];
         end
      end
      ones_clip = (ones > room_ff) ? room_ff : ones;
   end

   // per-bank memory control
   always_comb begin
      logic [LANE_W-1:0] lane;
      for (int b = 0; b < LANE_BYTES; b++) begin
         mark_we[b] = 1'b0;
         mark_wd[b] = 1'b0;
         mark_wa[b] = '0;
         mark_ra[b] = bank_row(contig_ff[SLOT_W-1:0], LANE_W'(b));
         byte_we[b] = 1'b0;
         byte_wa[b] = bank_row(cur_ff.offset[SLOT_W-1:0], LANE_W'(b));
         byte_ra[b] = bank_row(consumed_ff[SLOT_W-1:0], LANE_W'(b));
         lane       = LANE_W'(b) - cur_ff.offset[LANE_W-1:0];
         byte_wd[b] = cur_ff.data[8*lane +: 8];
         case (state_ff)
            S_CLEAR: begin
               mark_we[b] = 1'b1;
               mark_wa[b] = clr_row_ff;
            end
            S_ACT: begin
               if (cur_ff.cmd == CMD_APPEND) begin
                  mark_we[b] = (status_ff == ST_OK) && ({1'b0, lane} >= skip_ff) &&
                               ({1'b0, lane} < cur_ff.count);
                  mark_wd[b] = 1'b1;
                  mark_wa[b] = byte_wa[b];
                  byte_we[b] = mark_we[b];
               end else begin
                  lane       = LANE_W'(b) - consumed_ff[LANE_W-1:0];
                  mark_we[b] = (status_ff == ST_OK) && ({1'b0, lane} < navail_ff);
                  mark_wa[b] = byte_ra[b];
               end
            end
            default: begin
            end
         endcase
      end
   end

   for (genvar g = 0; g < LANE_BYTES; g++) begin : g_bank
      logic       mark_mem [ROWS];
      logic [7:0] byte_mem [ROWS];
      always_ff @(posedge clock) begin
         if (mark_we[g]) begin
            mark_mem[mark_wa[g]] <= mark_wd[g];
         end
         mark_rd_ff[g] <= mark_mem[mark_ra[g]];
      end
      always_ff @(posedge clock) begin
         if (byte_we[g]) begin
            byte_mem[byte_wa[g]] <= byte_wd[g];
         end
         byte_rd_ff[g] <= byte_mem[byte_ra[g]];
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      clr_row_in     = clr_row_ff;
      cur_in         = cur_ff;
      contig_in      = contig_ff;
      consumed_in    = consumed_ff;
      lim_in         = lim_ff;
      final_known_in = final_known_ff;
      final_size_in  = final_size_ff;
      status_in      = status_ff;
      skip_in        = skip_ff;
      navail_in      = navail_ff;
      room_in        = room_ff;
      rdata_in       = rdata_ff;
      rcount_in      = rcount_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_row_in = clr_row_ff + 1'b1;
            if (clr_row_ff == ROW_W'(ROWS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               cur_in   = q_data;
               state_in = S_CLASS;
            end
         end
         S_CLASS: begin
            status_in = (cur_ff.cmd == CMD_APPEND) ? a_status : r_status;
            skip_in   = skip_c;
            navail_in = navail_c;
            rdata_in  = '0;
            rcount_in = '0;
            state_in  = S_ACT;
         end
         S_ACT: begin
            state_in = S_RESP;
            if (status_ff == ST_OK) begin
               if (cur_ff.cmd == CMD_APPEND) begin
                  if (cur_ff.fin) begin
                     final_known_in = 1'b1;
                     final_size_in  = cur_ff.end_pos[OFS_W-1:0];
                  end
                  state_in = S_SCAN_RD;
               end else begin
                  state_in = S_RD_DATA;
               end
            end
         end
         S_SCAN_RD: begin
            room_in  = room_c;
            state_in = S_SCAN_EV;
         end
         S_SCAN_EV: begin
            contig_in = contig_ff + OFS_W'(ones_clip);
            state_in  = (ones_clip == CNT_W'(LANE_BYTES)) ? S_SCAN_RD : S_RESP;
         end
         S_RD_DATA: begin
            rdata_in    = rdata_c;
            rcount_in   = navail_ff;
            consumed_in = consumed_ff + OFS_W'(navail_ff);
            lim_in      = lim_ff + (OFS_W+1)'(navail_ff);
            state_in    = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.status           = status_ff;
               rsp_data_in.read_data        = rdata_ff;
               rsp_data_in.read_count       = rcount_ff;
               rsp_data_in.contiguous_point = contig_ff;
               state_in                     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_row_ff     <= '0;
         contig_ff      <= '0;
         consumed_ff    <= '0;
         lim_ff         <= (OFS_W+1)'(BUF_BYTES);
         final_known_ff <= 1'b0;
         final_size_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_row_ff     <= clr_row_in;
         contig_ff      <= contig_in;
         consumed_ff    <= consumed_in;
         lim_ff         <= lim_in;
         final_known_ff <= final_known_in;
         final_size_ff  <= final_size_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      cur_ff      <= cur_in;
      status_ff   <= status_in;
      skip_ff     <= skip_in;
      navail_ff   <= navail_in;
      room_ff     <= room_in;
      rdata_ff    <= rdata_in;
      rcount_ff   <= rcount_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTH
   a_contig_order: assert property (@(posedge clock) disable iff (reset)
      contig_ff >= consumed_ff) else $error("contiguous point below consumed point");
   a_contig_limit: assert property (@(posedge clock) disable iff (reset)
      {1'b0, contig_ff} <= lim_ff) else $error("contiguous point beyond window");
   a_limit_track: assert property (@(posedge clock) disable iff (reset)
      lim_ff == {1'b0, consumed_ff} + (OFS_W+1)'(BUF_BYTES))
      else $error("window limit out of step");
   a_final_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(final_known_ff)) else $error("final size forgotten");
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP))
      else $error("result raised outside response state");
`endif

endmodule

### verif/tb_stream_reassembly_buffer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stream_reassembly_buffer
// drives append and read requests into the reassembly buffer, predicts every
// response with a behavioral copy of the buffer and compares field by field
// ----------------------------------------------------------------------------
module tb_stream_reassembly_buffer;
   import srb_pkg::*;

   localparam longint LIMIT_CYCLES = 3000000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   stream_reassembly_buffer uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // buffer image
   logic [7:0]       bytes_img [BUF_BYTES];
   bit               marks_img [BUF_BYTES];
   logic [OFS_W-1:0] contig_pos;
   logic [OFS_W-1:0] consumed_pos;
   bit               fin_seen;
   logic [OFS_W-1:0] stream_len;

   rsp_type expected_rsp[$];
   int      fail_count;
   longint  cycle_count;
   int      send_idle_pct;
   int      recv_idle_pct;
   int      hold_cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
      fail_count++;
   endtask

   function automatic void clear_image();
      for (int i = 0; i < BUF_BYTES; i++) begin
         marks_img[i] = 1'b0;
         bytes_img[i] = 8'h00;
      end
      contig_pos   = '0;
      consumed_pos = '0;
      fin_seen     = 1'b0;
      stream_len   = '0;
   endfunction

   function automatic rsp_type predict_buffer(input req_type r);
      rsp_type     o;
      int unsigned n;
      logic [63:0] ofs, fin_end, lim, avail;
      int unsigned skip;
      o = '0;
      n = (r.byte_count > LANE_BYTES) ? LANE_BYTES : r.byte_count;
      if (r.cmd == CMD_APPEND) begin
         ofs     = {2'b00, r.stream_offset};
         fin_end = ofs + n;
         if (fin_end <= contig_pos) o.status = ST_OLD;
         else if (fin_end > {2'b00, consumed_pos} + BUF_BYTES ||
                  fin_end > 64'h3FFF_FFFF_FFFF_FFFF) o.status = ST_FLOW;
         else if (fin_seen && fin_end > stream_len) o.status = ST_FINAL;
         else if (r.fin_flag && fin_seen && fin_end != stream_len) o.status = ST_FINAL;
         else begin
            o.status = ST_OK;
            if (r.fin_flag) begin
               fin_seen   = 1'b1;
               stream_len = fin_end[OFS_W-1:0];
            end
            skip = (ofs < contig_pos) ? int'(contig_pos - ofs) : 0;
            for (int unsigned i = skip; i < n; i++) begin
               bytes_img[(ofs + i) % BUF_BYTES] = r.chunk_data[8*i +: 8];
               marks_img[(ofs + i) % BUF_BYTES] = 1'b1;
            end
            lim = {2'b00, consumed_pos} + BUF_BYTES;
            while (contig_pos < lim && marks_img[contig_pos % BUF_BYTES])
               contig_pos++;
         end
      end else begin
         avail = contig_pos - consumed_pos;
         if (fin_seen && ({2'b00, consumed_pos} + n > stream_len ||
                          consumed_pos == stream_len)) o.status = ST_END;
         else if (avail < n) o.status = ST_WAIT;
         else begin
            o.status     = ST_OK;
            o.read_count = (avail > LANE_BYTES) ? CNT_W'(LANE_BYTES) : avail[CNT_W-1:0];
            for (int i = 0; i < o.read_count; i++) begin
               o.read_data[8*i +: 8] = bytes_img[(consumed_pos + i) % BUF_BYTES];
               marks_img[(consumed_pos + i) % BUF_BYTES] = 1'b0;
            end
            consumed_pos = consumed_pos + o.read_count;
         end
      end
      o.contiguous_point = contig_pos;
      return o;
   endfunction

   task automatic send_request(input req_type r);
      if (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99, 0) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_rsp.push_back(predict_buffer(r));
   endtask

   // receiver side
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready   <= 1'b0;
      end else rsp_ready <= !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            report("unexpected response", 64'(rsp_data.status), '0);
         end else begin
            rsp_type e;
            e = expected_rsp.pop_front();
            if (rsp_data.status !== e.status)
               report("status", 64'(rsp_data.status), 64'(e.status));
            if (rsp_data.read_data !== e.read_data)
               report("read_data", rsp_data.read_data, e.read_data);
            if (rsp_data.read_count !== e.read_count)
               report("read_count", 64'(rsp_data.read_count), 64'(e.read_count));
            if (rsp_data.contiguous_point !== e.contiguous_point)
               report("contiguous_point", 64'(rsp_data.contiguous_point),
                      64'(e.contiguous_point));
         end
      end
   end

   function automatic req_type make_append(input logic [OFS_W-1:0] ofs, input int cnt,
                                           input bit fin);
      req_type r;
      r.cmd           = CMD_APPEND;
      r.stream_offset = ofs;
      r.chunk_data    = {$urandom, $urandom};
      r.byte_count    = CNT_W'(cnt);
      r.fin_flag      = fin;
      return r;
   endfunction

   function automatic req_type make_read(input int cnt);
      req_type r;
      r.cmd           = CMD_READ;
      r.stream_offset = OFS_W'({$urandom, $urandom});
      r.chunk_data    = {$urandom, $urandom};
      r.byte_count    = CNT_W'(cnt);
      r.fin_flag      = 1'($urandom_range(1, 0));
      return r;
   endfunction

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_request(make_read(0));
      send_request(make_append(0, 4, 0));
      send_request(make_append(8, 15, 0));
      send_request(make_append(4, 4, 0));
      send_request(make_append(0, 3, 1));
      send_request(make_append(2, 6, 0));
      send_request(make_read(15));
      send_request(make_read(8));
      send_request(make_read(3));
      send_request(make_append(16 + BUF_BYTES, 4, 0));
      send_request(make_append({OFS_W{1'b1}}, 8, 1));
      send_request(make_append(24, 0, 0));
      send_request(make_append(30, 2, 1));
      send_request(make_append(40, 2, 0));
      send_request(make_append(28, 2, 1));
      send_request(make_append(16, 8, 0));
      send_request(make_append(16, 8, 0));
      send_request(make_append(24, 6, 0));
      send_request(make_read(9));
      send_request(make_read(8));
      send_request(make_read(8));
      send_request(make_read(0));
      drain();
   endtask

   // shuffled chunks near the contiguous point and random reads, mixed with noise
   task automatic test_random_stream(input int items);
      int sent;
      int len;
      sent = 0;
      while (sent < items) begin
         int k;
         k = $urandom_range(99, 0);
         if (k < 50) begin
            len = $urandom_range(8, 1);
            send_request(make_append(contig_pos + $urandom_range(200, 0) - 40, len,
                                     1'($urandom_range(199, 0) == 0)));
         end else if (k < 88) begin
            send_request(make_read($urandom_range(15, 0)));
         end else if (k < 96) begin
            send_request(make_append(consumed_pos + BUF_BYTES - $urandom_range(12, 0),
                                     $urandom_range(15, 0), 1'($urandom_range(1, 0))));
         end else begin
            send_request(make_append(OFS_W'({$urandom, $urandom}), $urandom_range(15, 0),
                                     1'($urandom_range(1, 0))));
         end
         sent++;
      end
   endtask

   task automatic test_backpressure();
      hold_cycles = 400;
      for (int i = 0; i < 40; i++)
         send_request(make_append(contig_pos + 8 * i, 8, 0));
      drain();
   endtask

   initial begin
      fail_count    = 0;
      cycle_count   = 0;
      hold_cycles   = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      clear_image();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      send_idle_pct = 36;
      recv_idle_pct = 79;
      test_random_stream(450);
      test_backpressure();
      send_idle_pct = 79;
      recv_idle_pct = 36;
      test_random_stream(450);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_stream(450);
      drain();
      repeat (1200) @(posedge clock);
      if (fail_count == 0 && expected_rsp.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
